### hw/rtl/bilinear_reparam_forward_jacobian_top_macros.svh
// Assertion macros for the bilinear reparameterization block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BILINEAR_REPARAM_FORWARD_JACOBIAN_TOP_MACROS_SVH
`define BILINEAR_REPARAM_FORWARD_JACOBIAN_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRFJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brfj: implication check failed");
`define BRFJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brfj: next-cycle check failed");
`else
`define BRFJ_ASSERT_IMP(lbl, ante, cons)
`define BRFJ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/brfj_pkg.sv
// Shared types and constants of the bilinear reparameterization block.
// No dependencies.
package brfj_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int FRONT_STAGES = 4;
  localparam int QUO_BITS     = 25;
  localparam int NUM_STAGES   = FRONT_STAGES + QUO_BITS + 1;
  localparam int DIV_XW       = 50;
  localparam int DIV_DW       = 33;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;
  localparam logic [23:0] POS_LIM  = 24'h7FFFFF;
  localparam logic [24:0] NEG_LIM  = 25'h0800000;

  typedef enum logic [1:0] {
    REG_ALPHA_ONE = 2'd0,
    REG_ALPHA_TWO = 2'd1,
    REG_BETA_ONE  = 2'd2,
    REG_BETA_TWO  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0] param_s;
    logic [16:0] param_t;
  } in_item_t;

  typedef struct packed {
    logic [16:0]        mapped_u;
    logic [16:0]        mapped_v;
    logic signed [23:0] du_by_ds;
    logic signed [23:0] du_by_dt;
    logic signed [23:0] dv_by_ds;
    logic signed [23:0] dv_by_dt;
    logic               clipped;
  } out_item_t;

  // per-direction flags that ride alongside the divider stages
  typedef struct packed {
    logic den_zero;
    logic zero_own;
    logic sat_own;
    logic zero_oth;
    logic sat_oth;
    logic neg_oth;
  } dir_flags_t;

  typedef struct packed {
    dir_flags_t u;
    dir_flags_t v;
  } side_t;

  // front-end result for one direction: numerators, denominators, flags
  typedef struct packed {
    logic [32:0] den;
    logic [32:0] nmap;
    logic [30:0] nown;
    logic [30:0] noth;
    logic [32:0] dsq;
    dir_flags_t  flags;
  } front_t;

endpackage

### hw/rtl/brfj_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; stage enables come from the owner's pipeline control.
module brfj_div #(
  parameter int XW = 50,
  parameter int DW = 33,
  parameter int QW = 25
) (
  input  logic          clk_i,
  input  logic [QW-1:0] en_i,
  input  logic [XW-1:0] x_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  localparam int SW = (XW > DW + QW) ? XW : DW + QW;

  logic [XW-1:0] r_q [QW];
  logic [DW-1:0] d_q [QW];
  logic [QW-1:0] q_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [XW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] sh;
    logic [SW-1:0] rx;
    logic          ge;

    if (j == 0) begin : g_first
      assign r_in = x_i;
      assign d_in = d_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign d_in = d_q[j-1];
      assign q_in = q_q[j-1];
    end

    assign sh = SW'(d_in) << K;
    assign rx = SW'(r_in);
    assign ge = (rx >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j] <= ge ? XW'(rx - sh) : r_in;
        d_q[j] <= d_in;
        q_q[j] <= q_in | (QW'(ge) << K);
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

### hw/rtl/brfj_front.sv
// Front end of one mapping direction: blend, denominators, numerators,
// saturation pre-checks. Uses brfj_pkg.
module brfj_front
  import brfj_pkg::*;
(
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  logic [15:0]             w1_i,
  input  logic [15:0]             w2_i,
  input  logic [16:0]             p_i,
  input  logic [16:0]             q_i,
  output front_t                  res_o
);

  // stage A
  logic [33:0] blend;
  logic [16:0] a_a_q, p_a_q;
  logic [15:0] diff_a_q;
  logic        negw_a_q;

  assign blend = 34'(w1_i) * 34'(q_i) + 34'(w2_i) * 34'(ONE_Q16 - q_i) + 34'(HALF_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_a_q    <= 17'(blend >> FRAC_BITS);
      p_a_q    <= p_i;
      negw_a_q <= (w1_i > w2_i);
      diff_a_q <= (w1_i > w2_i) ? (w1_i - w2_i) : (w2_i - w1_i);
    end
  end

  // stage B
  logic [16:0] oma, omp;
  logic [33:0] ppr;
  logic [32:0] den_b_q, nmap_b_q;
  logic [30:0] nown_b_q;
  logic [14:0] pp_b_q;
  logic [15:0] diff_b_q;
  logic        negw_b_q;

  assign oma = ONE_Q16 - a_a_q;
  assign omp = ONE_Q16 - p_a_q;
  assign ppr = 34'(p_a_q) * 34'(omp) + 34'(HALF_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      den_b_q  <= 33'(34'(a_a_q) * 34'(omp) + 34'(p_a_q) * 34'(oma));
      nmap_b_q <= 33'(34'(oma) * 34'(p_a_q));
      nown_b_q <= 31'(34'(a_a_q) * 34'(oma));
      pp_b_q   <= 15'(ppr >> FRAC_BITS);
      diff_b_q <= diff_a_q;
      negw_b_q <= negw_a_q;
    end
  end

  // stage C: round the denominator and square it
  logic [33:0] dr_full;
  logic [16:0] dr;
  logic [32:0] den_c_q, nmap_c_q, dsq_c_q;
  logic [30:0] nown_c_q, noth_c_q;
  logic        neg_c_q;

  assign dr_full = 34'(den_b_q) + 34'(HALF_Q16);
  assign dr      = 17'(dr_full >> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      den_c_q  <= den_b_q;
      nmap_c_q <= nmap_b_q;
      nown_c_q <= nown_b_q;
      dsq_c_q  <= 33'(34'(dr) * 34'(dr));
      noth_c_q <= 31'(pp_b_q) * 31'(diff_b_q);
      neg_c_q  <= negw_b_q && (pp_b_q != '0);
    end
  end

  // stage D: a rounded quotient beyond the limit iff N*2^17 >= (2*lim+1)*D
  logic [57:0] nx_own, nx_oth, lim_pos, lim_neg;

  assign nx_own  = 58'(nown_c_q) << 17;
  assign nx_oth  = 58'(noth_c_q) << 17;
  assign lim_pos = (58'(dsq_c_q) << 24) - 58'(dsq_c_q);
  assign lim_neg = (58'(dsq_c_q) << 24) + 58'(dsq_c_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_o.den            <= den_c_q;
      res_o.nmap           <= nmap_c_q;
      res_o.nown           <= nown_c_q;
      res_o.noth           <= noth_c_q;
      res_o.dsq            <= dsq_c_q;
      res_o.flags.den_zero <= (den_c_q == '0);
      res_o.flags.zero_own <= (nown_c_q == '0);
      res_o.flags.sat_own  <= (nown_c_q != '0) && (nx_own >= lim_pos);
      res_o.flags.zero_oth <= (noth_c_q == '0);
      res_o.flags.sat_oth  <= (noth_c_q != '0) &&
                              (nx_oth >= (neg_c_q ? lim_neg : lim_pos));
      res_o.flags.neg_oth  <= neg_c_q;
    end
  end

endmodule

### hw/rtl/bilinear_reparam_forward_jacobian_top.sv
// Top level of the bilinear reparameterization block with Jacobian output.
// Uses brfj_pkg, brfj_front, brfj_div and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes a pair (s,t),
//   unsigned Q1.16; values above one are clamped to one. Output channel
//   (out_valid_o / out_stall_i / out_data_o) gives the mapped pair (u,v),
//   the four Jacobian partials in signed Q7.16 and a clipped flag.
//   An item moves when valid is high and stall is low.
//   Config port (cfg_valid_i / cfg_ready_o) writes the four weights by
//   index; it is always ready. Write only while the pipeline is empty.
// Pipeline:
//   Four front-end stages (blend, products, squared denominator, limit
//   checks), 25 stages of the restoring dividers (one quotient bit per
//   stage, six dividers side by side) and one output register.
//   Throughput is one item per cycle while the output is not stalled.
// Reset and stall:
//   Reset empties the pipeline and sets every weight to one half.
//   When the receiver stalls, items close up into empty stages; the input
//   stalls only once stage zero holds an item that cannot move.
`include "bilinear_reparam_forward_jacobian_top_macros.svh"

module bilinear_reparam_forward_jacobian_top
  import brfj_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int DIV_BASE = FRONT_STAGES;
  localparam int OUT_STG  = NUM_STAGES - 1;

  // Configuration registers
  logic [15:0] alpha_one_q, alpha_two_q, beta_one_q, beta_two_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_one_q <= 16'h8000;
      alpha_two_q <= 16'h8000;
      beta_one_q  <= 16'h8000;
      beta_two_q  <= 16'h8000;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ALPHA_ONE: alpha_one_q <= cfg_data_i;
        REG_ALPHA_TWO: alpha_two_q <= cfg_data_i;
        REG_BETA_ONE:  beta_one_q  <= cfg_data_i;
        REG_BETA_TWO:  beta_two_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Pipeline control: a stage advances when it is empty or the next one advances
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[OUT_STG] = !v_q[OUT_STG] || !out_stall_i;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[OUT_STG];

  // Clamp inputs to one
  logic [16:0] s_cl, t_cl;
  assign s_cl = (in_data_i.param_s > ONE_Q16) ? ONE_Q16 : in_data_i.param_s;
  assign t_cl = (in_data_i.param_t > ONE_Q16) ? ONE_Q16 : in_data_i.param_t;

  // Front ends: u maps s and blends along t, v the other way round
  front_t fu, fv;

  brfj_front u_front_u (
    .clk_i (clk_i),
    .en_i  (rdy[FRONT_STAGES-1:0]),
    .w1_i  (alpha_one_q),
    .w2_i  (alpha_two_q),
    .p_i   (s_cl),
    .q_i   (t_cl),
    .res_o (fu)
  );

  brfj_front u_front_v (
    .clk_i (clk_i),
    .en_i  (rdy[FRONT_STAGES-1:0]),
    .w1_i  (beta_one_q),
    .w2_i  (beta_two_q),
    .p_i   (t_cl),
    .q_i   (s_cl),
    .res_o (fv)
  );

  // Dividers: each gives floor(N * 2^17 / D)
  logic [QUO_BITS-1:0] q_mu, q_us, q_ut, q_mv, q_vt, q_vs;
  logic [QUO_BITS-1:0] div_en;
  assign div_en = rdy[DIV_BASE +: QUO_BITS];

  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_mu (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fu.nmap) << 17), .d_i (fu.den), .q_o (q_mu));
  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_us (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fu.nown) << 17), .d_i (fu.dsq), .q_o (q_us));
  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_ut (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fu.noth) << 17), .d_i (fu.dsq), .q_o (q_ut));
  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_mv (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fv.nmap) << 17), .d_i (fv.den), .q_o (q_mv));
  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_vt (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fv.nown) << 17), .d_i (fv.dsq), .q_o (q_vt));
  brfj_div #(.XW(DIV_XW), .DW(DIV_DW), .QW(QUO_BITS)) u_div_vs (
    .clk_i (clk_i), .en_i (div_en),
    .x_i (DIV_XW'(fv.noth) << 17), .d_i (fv.dsq), .q_o (q_vs));

  // Flags travel beside the divider stages
  side_t sb_q [QUO_BITS];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QUO_BITS; j++) begin
      if (div_en[j]) begin
        sb_q[j] <= (j == 0) ? side_t'{u: fu.flags, v: fv.flags}
                            : sb_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Output stage: round half up, then apply zero, limit and sign
  function automatic logic [24:0] round_q(input logic [QUO_BITS-1:0] q);
    logic [QUO_BITS:0] r;
    r = (QUO_BITS + 1)'(q) + 1'b1;
    return r[QUO_BITS:1];
  endfunction

  function automatic logic [23:0] own_val(input logic [QUO_BITS-1:0] q,
                                          input logic zero, input logic sat);
    logic [24:0] rq;
    rq = round_q(q);
    return zero ? '0 : (sat ? POS_LIM : rq[23:0]);
  endfunction

  function automatic logic [23:0] oth_val(input logic [QUO_BITS-1:0] q,
                                          input logic zero, input logic sat,
                                          input logic neg);
    logic [24:0] mag;
    mag = zero ? '0 : (sat ? (neg ? NEG_LIM : 25'(POS_LIM)) : round_q(q));
    return neg ? 24'(-mag) : mag[23:0];
  endfunction

  side_t     sbl;
  out_item_t out_d, out_q;
  logic [24:0] mu_r, mv_r;

  assign sbl  = sb_q[QUO_BITS-1];
  assign mu_r = round_q(q_mu);
  assign mv_r = round_q(q_mv);

  always_comb begin
    out_d.mapped_u = sbl.u.den_zero ? '0 : mu_r[16:0];
    out_d.mapped_v = sbl.v.den_zero ? '0 : mv_r[16:0];
    out_d.du_by_ds = own_val(q_us, sbl.u.zero_own, sbl.u.sat_own);
    out_d.du_by_dt = oth_val(q_ut, sbl.u.zero_oth, sbl.u.sat_oth, sbl.u.neg_oth);
    out_d.dv_by_dt = own_val(q_vt, sbl.v.zero_own, sbl.v.sat_own);
    out_d.dv_by_ds = oth_val(q_vs, sbl.v.zero_oth, sbl.v.sat_oth, sbl.v.neg_oth);
    out_d.clipped  = sbl.u.sat_own | sbl.u.sat_oth | sbl.v.sat_own | sbl.v.sat_oth;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_STG]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // Checks
  `BRFJ_ASSERT_IMP(a_stall_only_when_full, in_stall_o, v_q[0] && v_q[OUT_STG])
  `BRFJ_ASSERT_NXT(a_head_holds, v_q[0] && !rdy[0], v_q[0])
  `BRFJ_ASSERT_IMP(a_mapped_in_range, out_valid_o,
                   (out_data_o.mapped_u <= ONE_Q16) && (out_data_o.mapped_v <= ONE_Q16))

endmodule
